[src/range_segment_translator_defines.svh]
// ----------------------------------------------------------------------------
// range segment translator assertion macros
// shared macros for concurrent checks, clocked on clk_i, reset by rst_ni
// ----------------------------------------------------------------------------
`ifndef RANGE_SEGMENT_TRANSLATOR_DEFINES_SVH
`define RANGE_SEGMENT_TRANSLATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check held outside reset
`define RSEGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication held outside reset
`define RSEGT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RSEGT_ASSERT(lbl, prop, msg)
`define RSEGT_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

[src/rsegt_pkg.sv]
// ----------------------------------------------------------------------------
// rsegt_pkg
// shared types and constants of the range segment translator
// ----------------------------------------------------------------------------
`default_nettype none

package rsegt_pkg;

  localparam int FIELD_W          = 48;
  localparam int MAX_SEGMENTS_DEF = 16;
  localparam int ADDR_BITS_DEF    = 48;

  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_INSERT    = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_UNUSED    = 2'd3
  } command_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [FIELD_W-1:0] seg_dest;
    logic [FIELD_W-1:0] seg_source;
    logic [FIELD_W-1:0] seg_length;
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_length;
  } item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] piece_start;
    logic [FIELD_W-1:0] piece_length;
    logic               piece_mapped;
    logic               status;
    logic               last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic ld_in;
    logic ack;
    logic ins_chk;
    logic ins_shift;
    logic tr_load;
    logic tr_rd;
    logic tr_se;
    logic tr_chk;
    logic tr_pre;
    logic tr_map;
    logic tr_end;
    logic tr_fin;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       shift_more;
    logic       rd_ok;
    logic       meet;
  } ctrl_sts_t;

endpackage

`default_nettype wire

[src/rsegt_ctrl.sv]
// ----------------------------------------------------------------------------
// rsegt_ctrl
// sequencer for clear, insert and translate commands
// ----------------------------------------------------------------------------
`default_nettype none

module rsegt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rsegt_pkg::ctrl_sts_t sts_i,
  output rsegt_pkg::ctrl_cmd_t cmd_o,
  output logic                busy_o
);
  import rsegt_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_ACK       = 12'b0000_0000_0010,
    S_INS_CHK   = 12'b0000_0000_0100,
    S_INS_SHIFT = 12'b0000_0000_1000,
    S_TR_LOAD   = 12'b0000_0001_0000,
    S_TR_RD     = 12'b0000_0010_0000,
    S_TR_SE     = 12'b0000_0100_0000,
    S_TR_CHK    = 12'b0000_1000_0000,
    S_TR_PRE    = 12'b0001_0000_0000,
    S_TR_MAP    = 12'b0010_0000_0000,
    S_TR_END    = 12'b0100_0000_0000,
    S_TR_FIN    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.ld_in = 1'b1;
          unique case (command_e'(sts_i.command))
            CMD_INSERT:    state_d = S_INS_CHK;
            CMD_TRANSLATE: state_d = S_TR_LOAD;
            default:       state_d = S_ACK;
          endcase
        end
      end
      S_ACK: begin
        cmd_o.ack = 1'b1;
        state_d   = S_IDLE;
      end
      S_INS_CHK: begin
        cmd_o.ins_chk = 1'b1;
        state_d       = sts_i.full ? S_IDLE : S_INS_SHIFT;
      end
      S_INS_SHIFT: begin
        cmd_o.ins_shift = 1'b1;
        if (!sts_i.shift_more) state_d = S_IDLE;
      end
      S_TR_LOAD: begin
        cmd_o.tr_load = 1'b1;
        state_d       = S_TR_RD;
      end
      S_TR_RD: begin
        cmd_o.tr_rd = 1'b1;
        state_d     = sts_i.rd_ok ? S_TR_SE : S_TR_END;
      end
      S_TR_SE: begin
        cmd_o.tr_se = 1'b1;
        state_d     = S_TR_CHK;
      end
      S_TR_CHK: begin
        cmd_o.tr_chk = 1'b1;
        state_d      = S_TR_PRE;
      end
      S_TR_PRE: begin
        cmd_o.tr_pre = 1'b1;
        state_d      = sts_i.meet ? S_TR_MAP : S_TR_RD;
      end
      S_TR_MAP: begin
        cmd_o.tr_map = 1'b1;
        state_d      = S_TR_RD;
      end
      S_TR_END: begin
        cmd_o.tr_end = 1'b1;
        state_d      = S_TR_FIN;
      end
      S_TR_FIN: begin
        cmd_o.tr_fin = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

[src/rsegt_dp.sv]
// ----------------------------------------------------------------------------
// rsegt_dp
// segment table, scan registers and result staging
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_segment_translator_defines.svh"

module rsegt_dp #(
  parameter int MAX_SEGMENTS = rsegt_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = rsegt_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsegt_pkg::item_t     item_i,
  input  rsegt_pkg::ctrl_cmd_t cmd_i,
  output rsegt_pkg::ctrl_sts_t sts_o,
  output rsegt_pkg::result_t   result_o,
  output logic                 result_valid_o
);
  import rsegt_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  typedef logic [ADDR_BITS-1:0] addr_t;

  function automatic addr_t sat_end(addr_t a, addr_t b);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_BITS] ? '1 : s[ADDR_BITS-1:0];
  endfunction

  function automatic result_t mk(addr_t st, addr_t len, logic mapped, logic stat,
                                 logic lst);
    result_t r;
    r.piece_start  = FIELD_W'(st);
    r.piece_length = FIELD_W'(len);
    r.piece_mapped = mapped;
    r.status       = stat;
    r.last         = lst;
    return r;
  endfunction

  // segment table
  addr_t dest_q [MAX_SEGMENTS];
  addr_t src_q  [MAX_SEGMENTS];
  addr_t len_q  [MAX_SEGMENTS];

  item_t            item_q, item_d;
  logic [CNT_W-1:0] count_q, count_d, pos_q, pos_d, idx_q, idx_d;
  addr_t            ss_q, ss_d, sl_q, sl_d, sd_q, sd_d, se_q, se_d;
  addr_t            rs_q, rs_d, re_q, re_d, lo_q, lo_d, hi_q, hi_d;
  addr_t            gend_q, gend_d, off_q, off_d, pse_q, pse_d;
  logic             meet_q, meet_d, first_q, first_d, pend_q, pend_d;
  result_t          hold_q, hold_d, res_q, res_d;
  logic             hvld_q, hvld_d, vld_q, vld_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  addr_t            wr_dst, wr_src, wr_len;
  logic [CNT_W-1:0] rd_ptr, pos_m1;
  logic [IDX_W-1:0] rd_idx;
  addr_t            dst_rd, src_rd, len_rd;
  addr_t            new_d, new_s, new_l;
  logic             push_en;
  result_t          push_r;

  assign new_d  = ADDR_BITS'(item_q.seg_dest);
  assign new_s  = ADDR_BITS'(item_q.seg_source);
  assign new_l  = ADDR_BITS'(item_q.seg_length);
  assign pos_m1 = pos_q - CNT_W'(1);
  assign rd_ptr = cmd_i.ins_shift ? pos_m1 : idx_q;
  assign rd_idx = rd_ptr[IDX_W-1:0];
  assign dst_rd = dest_q[rd_idx];
  assign src_rd = src_q[rd_idx];
  assign len_rd = len_q[rd_idx];

  assign sts_o.command    = item_q.command;
  assign sts_o.full       = (count_q >= CNT_W'(MAX_SEGMENTS));
  assign sts_o.shift_more = (pos_q != '0) && (src_rd > new_s);
  assign sts_o.rd_ok      = (idx_q < count_q) && (re_q > rs_q);
  assign sts_o.meet       = meet_q;

  always_comb begin
    item_d  = item_q;
    count_d = count_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    ss_d    = ss_q;
    sl_d    = sl_q;
    sd_d    = sd_q;
    se_d    = se_q;
    rs_d    = rs_q;
    re_d    = re_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    gend_d  = gend_q;
    off_d   = off_q;
    pse_d   = pse_q;
    meet_d  = meet_q;
    first_d = first_q;
    pend_d  = pend_q;
    hold_d  = hold_q;
    hvld_d  = hvld_q;
    res_d   = res_q;
    vld_d   = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = pos_q[IDX_W-1:0];
    wr_dst  = new_d;
    wr_src  = new_s;
    wr_len  = new_l;
    push_en = 1'b0;
    push_r  = '0;

    if (cmd_i.ld_in) item_d = item_i;

    if (cmd_i.ack) begin
      res_d = mk('0, '0, 1'b0, 1'b0, 1'b1);
      vld_d = 1'b1;
      if (item_q.command == CMD_CLEAR) count_d = '0;
    end

    if (cmd_i.ins_chk) begin
      pos_d = count_q;
      if (sts_o.full) begin
        res_d = mk('0, '0, 1'b0, 1'b1, 1'b1);
        vld_d = 1'b1;
      end
    end

    if (cmd_i.ins_shift) begin
      wr_en = 1'b1;
      if (sts_o.shift_more) begin
        // move the entry below up by one
        wr_dst = dst_rd;
        wr_src = src_rd;
        wr_len = len_rd;
        pos_d  = pos_m1;
      end else begin
        count_d = count_q + CNT_W'(1);
        res_d   = mk('0, '0, 1'b0, 1'b0, 1'b1);
        vld_d   = 1'b1;
      end
    end

    if (cmd_i.tr_load) begin
      rs_d    = ADDR_BITS'(item_q.range_start);
      re_d    = sat_end(ADDR_BITS'(item_q.range_start), ADDR_BITS'(item_q.range_length));
      idx_d   = '0;
      first_d = 1'b1;
      pend_d  = 1'b0;
      hvld_d  = 1'b0;
    end

    if (cmd_i.tr_rd) begin
      ss_d = src_rd;
      sl_d = len_rd;
      sd_d = dst_rd;
    end

    if (cmd_i.tr_se) se_d = sat_end(ss_q, sl_q);

    if (cmd_i.tr_chk) begin
      meet_d = (sl_q != '0) && (se_q > ss_q) && (re_q > ss_q) && (rs_q < se_q);
      lo_d   = (rs_q > ss_q) ? rs_q : ss_q;
      hi_d   = (re_q < se_q) ? re_q : se_q;
      gend_d = (re_q < ss_q) ? re_q : ss_q;
    end

    if (cmd_i.tr_pre) begin
      if (meet_q) begin
        first_d = 1'b0;
        pend_d  = 1'b0;
        off_d   = lo_q - ss_q;
        if (first_q && (rs_q < ss_q)) begin
          push_en = 1'b1;
          push_r  = mk(rs_q, ss_q - rs_q, 1'b0, 1'b0, 1'b0);
        end else if (pend_q && (gend_q > pse_q)) begin
          push_en = 1'b1;
          push_r  = mk(pse_q, gend_q - pse_q, 1'b0, 1'b0, 1'b0);
        end
      end else begin
        idx_d = idx_q + CNT_W'(1);
      end
    end

    if (cmd_i.tr_map) begin
      push_en = 1'b1;
      push_r  = mk(off_q + sd_q, hi_q - lo_q, 1'b1, 1'b0, 1'b0);
      pend_d  = (re_q > se_q);
      pse_d   = se_q;
      idx_d   = idx_q + CNT_W'(1);
    end

    if (cmd_i.tr_end && pend_q && (re_q > pse_q)) begin
      push_en = 1'b1;
      push_r  = mk(pse_q, re_q - pse_q, 1'b0, 1'b0, 1'b0);
    end

    if (cmd_i.tr_fin) begin
      vld_d  = 1'b1;
      hvld_d = 1'b0;
      if (hvld_q) begin
        res_d      = hold_q;
        res_d.last = 1'b1;
      end else begin
        res_d = mk(rs_q, (re_q > rs_q) ? (re_q - rs_q) : '0, 1'b0, 1'b0, 1'b1);
      end
    end

    // one-deep hold so the final piece can carry last
    if (push_en) begin
      if (hvld_q) begin
        res_d = hold_q;
        vld_d = 1'b1;
      end
      hold_d = push_r;
      hvld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      vld_q   <= 1'b0;
      hvld_q  <= 1'b0;
      first_q <= 1'b0;
      pend_q  <= 1'b0;
      meet_q  <= 1'b0;
      pos_q   <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      vld_q   <= vld_d;
      hvld_q  <= hvld_d;
      first_q <= first_d;
      pend_q  <= pend_d;
      meet_q  <= meet_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ss_q   <= ss_d;
    sl_q   <= sl_d;
    sd_q   <= sd_d;
    se_q   <= se_d;
    rs_q   <= rs_d;
    re_q   <= re_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    gend_q <= gend_d;
    off_q  <= off_d;
    pse_q  <= pse_d;
    hold_q <= hold_d;
    res_q  <= res_d;
    if (wr_en) begin
      dest_q[wr_idx] <= wr_dst;
      src_q[wr_idx]  <= wr_src;
      len_q[wr_idx]  <= wr_len;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = vld_q;

  `RSEGT_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_SEGMENTS), "segment count over limit")
  `RSEGT_ASSERT_IMP(a_hold_idle, cmd_i.ld_in, !hvld_q, "piece held while idle")
  `RSEGT_ASSERT_IMP(a_full_ack, vld_q && res_q.status, res_q.piece_length == '0 && res_q.last,
                    "full status on a piece")

endmodule

`default_nettype wire

[src/range_segment_translator.sv]
// ----------------------------------------------------------------------------
// range_segment_translator
// sorted segment table with piecewise translation of address ranges
// ----------------------------------------------------------------------------
// usage:
//   a command beat is taken at a rising edge with start high and busy low.
//   clear and insert give one ack beat; translate gives one beat per piece,
//   gaps and uncovered tails unmapped, covered parts shifted by dest - source,
//   in ascending source order. last marks the final beat of a command.
//   result beats sit on result_o for one cycle each, flagged by result_valid_o;
//   the receiver cannot stall, so there is no backpressure at all.
// sequencing:
//   clear and unused commands pass the ack state; insert shifts one entry per step
//   to free the new entry's slot, and an insert into a full table stops after the
//   room check. translate scans the table one segment per step, mapping a piece
//   where a segment meets the range. the single read port of the segment table
//   sets this pace: one entry is read per step of the insert shift or the
//   translate scan. busy drops in the cycle that carries the last beat, so the
//   next command can be taken at the edge that ends that cycle.
// reset:
//   the table becomes empty; no beats are pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module range_segment_translator #(
  parameter int MAX_SEGMENTS = rsegt_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = rsegt_pkg::ADDR_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  rsegt_pkg::item_t   item_i,
  output rsegt_pkg::result_t result_o,
  output logic               result_valid_o
);
  import rsegt_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // raw command bits are needed in the accept cycle for the branch
  ctrl_sts_t sts_ctrl;

  always_comb begin
    sts_ctrl = sts;
    if (!busy) sts_ctrl.command = item_i.command;
  end

  rsegt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts_ctrl),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  rsegt_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire
